@@ rtl/rbe_pkg.sv @@
`default_nettype none
package rbe_pkg;

    localparam int CORDIC_STEPS = 16;

    localparam int PW = 32;                 // position width, Q15.16
    localparam int QW = 16;                 // quaternion component width, Q1.14
    localparam int VW = 36;                 // rotated vector component width, Q16
    localparam int CW = 40;                 // CORDIC x and y width
    localparam int AW = 32;                 // CORDIC angle accumulator width, Q30

    localparam logic signed [AW-1:0] HALF_PI_Q30 = 32'sd1686629713;
    localparam logic signed [15:0]   PI_Q13      = 16'sd25736;
    localparam logic signed [15:0]   HALF_PI_Q13 = 16'sd12868;

    localparam int REG_TARGET_X = 0;
    localparam int REG_TARGET_Y = 1;
    localparam int REG_TARGET_Z = 2;

    typedef struct packed {
        logic                   zero;
        logic signed [VW-1:0]   z;
        logic signed [AW-1:0]   off;
        logic signed [15:0]     bear;
    } side_t;

    function automatic logic signed [AW-1:0] atan_q30(input int i);
        logic signed [AW-1:0] a;
        case (i)
            0:       a = 32'h3243F6A8;
            1:       a = 32'h1DAC6705;
            2:       a = 32'h0FADBAFC;
            3:       a = 32'h07F56EA6;
            4:       a = 32'h03FEAB76;
            5:       a = 32'h01FFD55B;
            6:       a = 32'h00FFFAAA;
            7:       a = 32'h007FFF55;
            8:       a = 32'h003FFFEA;
            9:       a = 32'h001FFFFD;
            10:      a = 32'h000FFFFF;
            11:      a = 32'h0007FFFF;
            12:      a = 32'h0003FFFF;
            13:      a = 32'h0001FFFF;
            14:      a = 32'h0000FFFF;
            15:      a = 32'h00007FFF;
            16:      a = 32'h00003FFF;
            17:      a = 32'h00001FFF;
            18:      a = 32'h00000FFF;
            19:      a = 32'h000007FF;
            20:      a = 32'h000003FF;
            21:      a = 32'h000001FF;
            22:      a = 32'h000000FF;
            23:      a = 32'h0000007F;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Inverse CORDIC gain in Q24, evaluated at elaboration.
    function automatic logic [24:0] inv_gain();
        logic [63:0] p;
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rem;
        logic [63:0] q;
        p = 64'd1 << 62;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            p = p + (p >> (2 * i));
        end
        n = p;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (b > n) begin
                b = b >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        rem = '0;
        q = '0;
        for (int i = 55; i >= 0; i--) begin
            rem = (rem << 1) | ((i == 55) ? 64'd1 : 64'd0);
            q = q << 1;
            if (rem >= r) begin
                rem = rem - r;
                q = q | 64'd1;
            end
        end
        return q[24:0];
    endfunction

    localparam logic [24:0] INV_GAIN = inv_gain();

endpackage
`default_nettype wire

@@ rtl/range_bearing_elevation_core.sv @@
// Throughput: one item per cycle; the whole pipeline advances together and holds
// while a result waits at the output.
// Reset: aresetn is synchronous, active low; it empties the pipeline and
// clears the target registers to zero.
`default_nettype none
module range_bearing_elevation_core
    import rbe_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // veh_x[31:0] veh_y[63:32] veh_z[95:64] quat_w[111:96] quat_x[127:112]
    // quat_y[143:128] quat_z[159:144]
    input  wire logic [159:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // range_out[31:0] bearing_out[47:32] elevation_out[62:48] range_clipped[63]
    output logic [63:0]       m_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic                 ce;
    logic signed [PW-1:0] tgt_x_reg, tgt_y_reg, tgt_z_reg;
    logic                 wr_en;

    logic                 rot_valid;
    logic signed [VW-1:0] v0, v1, v2;

    logic                 pre_valid_reg;
    logic signed [CW-1:0] pre_x_reg, pre_y_reg;
    side_t                pre_side_reg;
    logic signed [CW-1:0] pre_x_next, pre_y_next;
    side_t                pre_side_next;

    logic                 c1_valid;
    logic signed [CW-1:0] c1_x;
    logic signed [AW-1:0] c1_ang;
    side_t                c1_side;

    logic                 g1_valid_reg;
    logic signed [65:0]   g1_prod_reg;
    logic signed [AW-1:0] g1_ang_reg;
    side_t                g1_side_reg;

    logic                 h_valid_reg;
    logic signed [CW-1:0] h_x_reg, h_y_reg;
    side_t                h_side_reg;
    logic signed [65:0]   h_round;
    logic signed [CW-1:0] h_next;
    logic signed [33:0]   bsum;
    logic signed [33:0]   brnd;
    logic signed [15:0]   bear_next;
    side_t                h_side_next;

    logic                 c2_valid;
    logic signed [CW-1:0] c2_x;
    logic signed [AW-1:0] c2_ang;
    side_t                c2_side;

    logic                 g2_valid_reg;
    logic signed [65:0]   g2_prod_reg;
    logic signed [14:0]   g2_elev_reg;
    logic                 g2_zero_reg;
    logic signed [15:0]   g2_bear_reg;
    logic signed [AW-1:0] ang2;
    logic signed [AW-1:0] ernd;
    logic signed [14:0]   elev_next;

    logic                 out_valid_reg;
    logic [63:0]          out_data_reg;
    logic signed [65:0]   rng;
    logic                 clip;
    logic [31:0]          range_val;

    assign ce       = m_tready || !out_valid_reg;
    assign s_tready = ce;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration port.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tgt_x_reg <= '0;
            tgt_y_reg <= '0;
            tgt_z_reg <= '0;
        end else if (wr_en) begin
            case (int'(paddr[3:2]))
                REG_TARGET_X: tgt_x_reg <= pwdata;
                REG_TARGET_Y: tgt_y_reg <= pwdata;
                REG_TARGET_Z: tgt_z_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (int'(paddr[3:2]))
            REG_TARGET_X: prdata = tgt_x_reg;
            REG_TARGET_Y: prdata = tgt_y_reg;
            REG_TARGET_Z: prdata = tgt_z_reg;
            default:      prdata = '0;
        endcase
    end

    rbe_rotate u_rotate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .veh_x     (s_tdata[31:0]),
        .veh_y     (s_tdata[63:32]),
        .veh_z     (s_tdata[95:64]),
        .quat_w    (s_tdata[111:96]),
        .quat_x    (s_tdata[127:112]),
        .quat_y    (s_tdata[143:128]),
        .quat_z    (s_tdata[159:144]),
        .target_x  (tgt_x_reg),
        .target_y  (tgt_y_reg),
        .target_z  (tgt_z_reg),
        .out_valid (rot_valid),
        .v0        (v0),
        .v1        (v1),
        .v2        (v2)
    );

    // A vector in the left half plane is turned by a quarter toward positive x.
    always_comb begin
        pre_side_next      = '0;
        pre_side_next.z    = v2;
        pre_side_next.zero = (v0 == '0) && (v1 == '0);
        pre_x_next         = CW'(v0);
        pre_y_next         = CW'(v1);
        if (v0[VW-1]) begin
            if (!v1[VW-1]) begin
                pre_x_next        = CW'(v1);
                pre_y_next        = -CW'(v0);
                pre_side_next.off = HALF_PI_Q30;
            end else begin
                pre_x_next        = -CW'(v1);
                pre_y_next        = CW'(v0);
                pre_side_next.off = -HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_valid_reg <= 1'b0;
            g1_valid_reg  <= 1'b0;
            h_valid_reg   <= 1'b0;
            g2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            pre_valid_reg <= rot_valid;
            g1_valid_reg  <= c1_valid;
            h_valid_reg   <= g1_valid_reg;
            g2_valid_reg  <= c2_valid;
            out_valid_reg <= g2_valid_reg;
        end
    end

    rbe_cordic u_cordic_bearing (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (pre_valid_reg),
        .in_x      (pre_x_reg),
        .in_y      (pre_y_reg),
        .in_side   (pre_side_reg),
        .out_valid (c1_valid),
        .out_x     (c1_x),
        .out_ang   (c1_ang),
        .out_side  (c1_side)
    );

    // Gain compensation of the horizontal length, and rounding and clamping of the bearing.
    always_comb begin
        h_round = (g1_prod_reg + 66'sd8388608) >>> 24;
        h_next  = g1_side_reg.zero ? '0 : h_round[CW-1:0];
        bsum    = g1_side_reg.zero ? '0 : (34'(g1_ang_reg) + 34'(g1_side_reg.off));
        brnd    = (bsum + 34'sd65536) >>> 17;
        if (brnd > 34'(PI_Q13)) begin
            bear_next = PI_Q13;
        end else if (brnd < -34'(PI_Q13)) begin
            bear_next = -PI_Q13;
        end else begin
            bear_next = brnd[15:0];
        end
        h_side_next      = g1_side_reg;
        h_side_next.bear = bear_next;
        h_side_next.zero = (h_next == '0) && (g1_side_reg.z == '0);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            pre_x_reg    <= pre_x_next;
            pre_y_reg    <= pre_y_next;
            pre_side_reg <= pre_side_next;
            g1_prod_reg  <= c1_x * $signed({1'b0, INV_GAIN});
            g1_ang_reg   <= c1_ang;
            g1_side_reg  <= c1_side;
            h_x_reg      <= h_next;
            h_y_reg      <= CW'(g1_side_reg.z);
            h_side_reg   <= h_side_next;
        end
    end

    rbe_cordic u_cordic_elevation (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (h_valid_reg),
        .in_x      (h_x_reg),
        .in_y      (h_y_reg),
        .in_side   (h_side_reg),
        .out_valid (c2_valid),
        .out_x     (c2_x),
        .out_ang   (c2_ang),
        .out_side  (c2_side)
    );

    always_comb begin
        ang2 = c2_side.zero ? '0 : c2_ang;
        ernd = (ang2 + 32'sd65536) >>> 17;
        if (ernd > AW'(HALF_PI_Q13)) begin
            elev_next = 15'(HALF_PI_Q13);
        end else if (ernd < -AW'(HALF_PI_Q13)) begin
            elev_next = -15'(HALF_PI_Q13);
        end else begin
            elev_next = ernd[14:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            g2_prod_reg  <= c2_x * $signed({1'b0, INV_GAIN});
            g2_elev_reg  <= elev_next;
            g2_zero_reg  <= c2_side.zero;
            g2_bear_reg  <= c2_side.bear;
            out_data_reg <= {clip, g2_elev_reg, g2_bear_reg, range_val};
        end
    end

    always_comb begin
        rng  = g2_zero_reg ? '0 : ((g2_prod_reg + 66'sd8388608) >>> 24);
        clip = rng > 66'sh0FFFFFFFF;
        if (clip) begin
            range_val = 32'hFFFFFFFF;
        end else if (rng[65]) begin
            range_val = '0;
        end else begin
            range_val = rng[31:0];
        end
    end

endmodule
`default_nettype wire

@@ rtl/rbe_rotate.sv @@
`default_nettype none
module rbe_rotate
    import rbe_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 ce,
    input  wire logic                 in_valid,
    input  wire logic signed [PW-1:0] veh_x,
    input  wire logic signed [PW-1:0] veh_y,
    input  wire logic signed [PW-1:0] veh_z,
    input  wire logic signed [QW-1:0] quat_w,
    input  wire logic signed [QW-1:0] quat_x,
    input  wire logic signed [QW-1:0] quat_y,
    input  wire logic signed [QW-1:0] quat_z,
    input  wire logic signed [PW-1:0] target_x,
    input  wire logic signed [PW-1:0] target_y,
    input  wire logic signed [PW-1:0] target_z,
    output logic                      out_valid,
    output logic signed [VW-1:0]      v0,
    output logic signed [VW-1:0]      v1,
    output logic signed [VW-1:0]      v2
);

    localparam logic signed [34:0] ONE_Q28 = 35'sd268435456;

    function automatic logic signed [29:0] clamp_q28(input logic signed [34:0] v);
        logic signed [29:0] r;
        if (v > ONE_Q28) begin
            r = 30'sd268435456;
        end else if (v < -ONE_Q28) begin
            r = -30'sd268435456;
        end else begin
            r = v[29:0];
        end
        return r;
    endfunction

    logic                    s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    // Quaternion products: xx yy zz xy xz yz wx wy wz.
    logic signed [31:0]      qp_reg [9];
    logic signed [PW:0]      d1_reg [3];
    logic signed [PW:0]      d2_reg [3];
    logic signed [29:0]      m_reg [9];
    logic signed [29:0]      m_next [9];
    logic signed [62:0]      p_reg [9];
    logic signed [62:0]      p_next [9];
    logic signed [VW-1:0]    v_reg [3];
    logic signed [VW-1:0]    v_next [3];
    logic signed [34:0]      e [9];
    logic signed [64:0]      s [3];
    logic signed [64:0]      rnd [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (ce) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            qp_reg[0] <= quat_x * quat_x;
            qp_reg[1] <= quat_y * quat_y;
            qp_reg[2] <= quat_z * quat_z;
            qp_reg[3] <= quat_x * quat_y;
            qp_reg[4] <= quat_x * quat_z;
            qp_reg[5] <= quat_y * quat_z;
            qp_reg[6] <= quat_w * quat_x;
            qp_reg[7] <= quat_w * quat_y;
            qp_reg[8] <= quat_w * quat_z;
            d1_reg[0] <= 33'(target_x) - 33'(veh_x);
            d1_reg[1] <= 33'(target_y) - 33'(veh_y);
            d1_reg[2] <= 33'(target_z) - 33'(veh_z);
            d2_reg    <= d1_reg;
            m_reg     <= m_next;
            p_reg     <= p_next;
            v_reg     <= v_next;
        end
    end

    // Matrix entries, indexed row * 3 + column.
    always_comb begin
        e[0] = ONE_Q28 - ((35'(qp_reg[1]) + 35'(qp_reg[2])) <<< 1);
        e[1] = (35'(qp_reg[3]) - 35'(qp_reg[8])) <<< 1;
        e[2] = (35'(qp_reg[4]) + 35'(qp_reg[7])) <<< 1;
        e[3] = (35'(qp_reg[3]) + 35'(qp_reg[8])) <<< 1;
        e[4] = ONE_Q28 - ((35'(qp_reg[0]) + 35'(qp_reg[2])) <<< 1);
        e[5] = (35'(qp_reg[5]) - 35'(qp_reg[6])) <<< 1;
        e[6] = (35'(qp_reg[4]) - 35'(qp_reg[7])) <<< 1;
        e[7] = (35'(qp_reg[5]) + 35'(qp_reg[6])) <<< 1;
        e[8] = ONE_Q28 - ((35'(qp_reg[0]) + 35'(qp_reg[1])) <<< 1);
        for (int k = 0; k < 9; k++) begin
            m_next[k] = clamp_q28(e[k]);
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            p_next[k] = 63'(m_reg[k]) * 63'(d2_reg[k / 3]);
        end
    end

    // Column c of the matrix gives component c of the transposed product.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            s[c] = 65'(p_reg[c]) + 65'(p_reg[3 + c]) + 65'(p_reg[6 + c]);
            rnd[c] = (s[c] + 65'sd134217728) >>> 28;
            v_next[c] = rnd[c][VW-1:0];
        end
    end

    assign out_valid = s4_valid_reg;
    assign v0 = v_reg[0];
    assign v1 = v_reg[1];
    assign v2 = v_reg[2];

endmodule
`default_nettype wire

@@ rtl/rbe_cordic.sv @@
`default_nettype none
module rbe_cordic
    import rbe_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 ce,
    input  wire logic                 in_valid,
    input  wire logic signed [CW-1:0] in_x,
    input  wire logic signed [CW-1:0] in_y,
    input  wire side_t                in_side,
    output logic                      out_valid,
    output logic signed [CW-1:0]      out_x,
    output logic signed [AW-1:0]      out_ang,
    output side_t                     out_side
);

    logic                 valid_reg [CORDIC_STEPS];
    logic signed [CW-1:0] x_reg [CORDIC_STEPS];
    logic signed [CW-1:0] y_reg [CORDIC_STEPS];
    logic signed [AW-1:0] a_reg [CORDIC_STEPS];
    side_t                side_reg [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic                 vi;
        logic signed [CW-1:0] xi, yi;
        logic signed [AW-1:0] ai;
        side_t                si;

        if (i == 0) begin : g_first
            assign vi = in_valid;
            assign xi = in_x;
            assign yi = in_y;
            assign ai = '0;
            assign si = in_side;
        end else begin : g_next
            assign vi = valid_reg[i-1];
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign ai = a_reg[i-1];
            assign si = side_reg[i-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (ce) begin
                valid_reg[i] <= vi;
            end
        end

        // A non-negative y turns the vector clockwise.
        always_ff @(posedge aclk) begin
            if (ce) begin
                side_reg[i] <= si;
                if (!yi[CW-1]) begin
                    x_reg[i] <= xi + (yi >>> i);
                    y_reg[i] <= yi - (xi >>> i);
                    a_reg[i] <= ai + atan_q30(i);
                end else begin
                    x_reg[i] <= xi - (yi >>> i);
                    y_reg[i] <= yi + (xi >>> i);
                    a_reg[i] <= ai - atan_q30(i);
                end
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_STEPS-1];
    assign out_x     = x_reg[CORDIC_STEPS-1];
    assign out_ang   = a_reg[CORDIC_STEPS-1];
    assign out_side  = side_reg[CORDIC_STEPS-1];

endmodule
`default_nettype wire

@@ rtl/rbe_checker.sv @@
`default_nettype none
module rbe_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [63:0]  m_tdata
);

    // A result that is not taken stays, unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[63] |-> m_tdata[31:0] == 32'hFFFFFFFF)
        else $error("clip flag without saturated range");

    a_bear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[47:32]) <= 16'sd25736)
                  && ($signed(m_tdata[47:32]) >= -16'sd25736))
        else $error("bearing out of range");

    a_elev: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[62:48]) <= 15'sd12868)
                  && ($signed(m_tdata[62:48]) >= -15'sd12868))
        else $error("elevation out of range");

    a_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind range_bearing_elevation_core rbe_checker u_rbe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
